>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL: clocked, gated by synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication on the next cycle, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> rtl/uart_trx_pkg.sv
// ----------------------------------------------------------------------------
// uart_trx_pkg
// Shared types and constants of the 8N1 UART transceiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uart_trx_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_HALF_BIT_TICKS    = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_HALF_BITS = 2'd1;

   // Reset values of the timing registers and of their derived values
   localparam logic [15:0] HALF_BIT_RESET  = 16'd456;
   localparam logic [7:0]  TIMEOUT_RESET   = 8'd10;
   localparam logic [16:0] BIT_TICKS_RESET = 17'd912;
   localparam logic [23:0] WINDOW_RESET    = 24'd4560;

   localparam int unsigned DATA_BITS = 8;

   // Receive status codes
   localparam logic [1:0] RX_OK          = 2'd0;
   localparam logic [1:0] RX_TIMEOUT     = 2'd1;
   localparam logic [1:0] RX_FALSE_START = 2'd2;

   typedef enum logic [3:0] {
      TX_IDLE  = 4'b0001,
      TX_START = 4'b0010,
      TX_DATA  = 4'b0100,
      TX_STOP  = 4'b1000
   } tx_phase_type;

   typedef enum logic [4:0] {
      RX_IDLE  = 5'b00001,
      RX_WAIT  = 5'b00010,
      RX_START = 5'b00100,
      RX_DATA  = 5'b01000,
      RX_STOP  = 5'b10000
   } rx_phase_type;

   typedef struct packed {
      logic       rx_line;
      logic       rx_arm;
      logic       tx_start;
      logic [7:0] tx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_line;
      logic       tx_busy;
      logic       rx_busy;
      logic       rx_done;
      logic [1:0] rx_status;
      logic [7:0] rx_byte;
   } rsp_type;

   // Bit timing derived from the configuration registers
   typedef struct packed {
      logic [15:0] half;
      logic [16:0] bit_ticks;
      logic [23:0] window;
   } timing_type;

   typedef struct packed {
      logic line;
      logic busy;
   } tx_out_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [1:0] status;
      logic [7:0] data;
   } rx_out_type;

endpackage

>>> rtl/uart_trx_tx.sv
// ----------------------------------------------------------------------------
// uart_trx_tx
// Transmit sequencer: start bit, eight data bits LSB first, stop bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_trx_tx (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    tx_start,
   input  logic [7:0]              tx_byte,
   input  uart_trx_pkg::timing_type timing,
   output uart_trx_pkg::tx_out_type tx_out
);

   uart_trx_pkg::tx_phase_type phase_ff, phase_in, phase_v;
   logic [7:0]  shift_ff, shift_in, shift_v;
   logic [3:0]  bit_ff, bit_in, bit_v, bit_inc;
   logic [16:0] tick_ff, tick_in, tick_v, tick_inc;

   always_comb begin
      phase_v = phase_ff;
      shift_v = shift_ff;
      bit_v   = bit_ff;
      tick_v  = tick_ff;
      // a new frame drives its start bit in the accepting tick
      if (phase_ff == uart_trx_pkg::TX_IDLE && tx_start) begin
         phase_v = uart_trx_pkg::TX_START;
         shift_v = tx_byte;
         bit_v   = '0;
         tick_v  = '0;
      end
      tick_inc = tick_v + 17'd1;
      bit_inc  = bit_v + 4'd1;

      phase_in    = phase_v;
      shift_in    = shift_v;
      bit_in      = bit_v;
      tick_in     = tick_v;
      tx_out.line = 1'b1;
      tx_out.busy = 1'b0;

      if (phase_v != uart_trx_pkg::TX_IDLE) begin
         tx_out.busy = 1'b1;
         case (phase_v)
            uart_trx_pkg::TX_START: tx_out.line = 1'b0;
            uart_trx_pkg::TX_DATA:  tx_out.line = shift_v[0];
            default:                tx_out.line = 1'b1;
         endcase
         tick_in = tick_inc;
         if (tick_inc >= timing.bit_ticks) begin
            tick_in = '0;
            case (phase_v)
               uart_trx_pkg::TX_START: begin
                  phase_in = uart_trx_pkg::TX_DATA;
                  bit_in   = '0;
               end
               uart_trx_pkg::TX_DATA: begin
                  shift_in = {1'b0, shift_v[7:1]};
                  bit_in   = bit_inc;
                  if (bit_inc >= 4'(uart_trx_pkg::DATA_BITS)) begin
                     phase_in = uart_trx_pkg::TX_STOP;
                  end
               end
               default: begin
                  phase_in = uart_trx_pkg::TX_IDLE;
                  bit_in   = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uart_trx_pkg::TX_IDLE;
         shift_ff <= '0;
         bit_ff   <= '0;
         tick_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

>>> rtl/uart_trx_rx.sv
// ----------------------------------------------------------------------------
// uart_trx_rx
// Receive sequencer: start wait with timeout, start recheck, mid-bit sampling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_trx_rx (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     rx_line,
   input  logic                     rx_arm,
   input  uart_trx_pkg::timing_type  timing,
   output uart_trx_pkg::rx_out_type  rx_out
);

   uart_trx_pkg::rx_phase_type phase_ff, phase_in, phase_v;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  bit_ff, bit_in, bit_inc;
   logic [23:0] tick_ff, tick_in, tick_v, tick_inc;

   always_comb begin
      phase_v = phase_ff;
      tick_v  = tick_ff;
      // the arming tick already looks at the line
      if (phase_ff == uart_trx_pkg::RX_IDLE && rx_arm) begin
         phase_v = uart_trx_pkg::RX_WAIT;
         tick_v  = '0;
      end
      tick_inc = tick_v + 24'd1;
      bit_inc  = bit_ff + 4'd1;

      phase_in      = phase_v;
      shift_in      = shift_ff;
      bit_in        = bit_ff;
      tick_in       = tick_v;
      rx_out.busy   = (phase_v != uart_trx_pkg::RX_IDLE);
      rx_out.done   = 1'b0;
      rx_out.status = uart_trx_pkg::RX_OK;
      rx_out.data   = '0;

      case (phase_v)
         uart_trx_pkg::RX_WAIT: begin
            if (tick_v >= timing.window) begin
               rx_out.done   = 1'b1;
               rx_out.status = uart_trx_pkg::RX_TIMEOUT;
               phase_in      = uart_trx_pkg::RX_IDLE;
               tick_in       = '0;
            end else if (!rx_line) begin
               phase_in = uart_trx_pkg::RX_START;
               tick_in  = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         uart_trx_pkg::RX_START: begin
            tick_in = tick_inc;
            if (tick_inc >= {8'd0, timing.half}) begin
               tick_in = '0;
               if (rx_line) begin
                  rx_out.done   = 1'b1;
                  rx_out.status = uart_trx_pkg::RX_FALSE_START;
                  phase_in      = uart_trx_pkg::RX_IDLE;
               end else begin
                  phase_in = uart_trx_pkg::RX_DATA;
                  shift_in = '0;
                  bit_in   = '0;
               end
            end
         end
         uart_trx_pkg::RX_DATA: begin
            tick_in = tick_inc;
            if (tick_inc >= {7'd0, timing.bit_ticks}) begin
               tick_in  = '0;
               shift_in = {rx_line, shift_ff[7:1]};
               bit_in   = bit_inc;
               if (bit_inc >= 4'(uart_trx_pkg::DATA_BITS)) begin
                  phase_in = uart_trx_pkg::RX_STOP;
               end
            end
         end
         uart_trx_pkg::RX_STOP: begin
            tick_in = tick_inc;
            if (tick_inc >= {7'd0, timing.bit_ticks}) begin
               tick_in     = '0;
               rx_out.done = 1'b1;
               rx_out.data = shift_ff;
               phase_in    = uart_trx_pkg::RX_IDLE;
               bit_in      = '0;
            end
         end
         default: begin
            phase_in = uart_trx_pkg::RX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uart_trx_pkg::RX_IDLE;
         shift_ff <= '0;
         bit_ff   <= '0;
         tick_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

>>> rtl/uart_trx_timing.sv
// ----------------------------------------------------------------------------
// uart_trx_timing
// Configuration registers and the registered bit timing derived from them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_trx_timing (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_wdata,
   output uart_trx_pkg::timing_type  timing
);

   logic [15:0] half_cfg_ff;
   logic [7:0]  timeout_cfg_ff;
   logic [15:0] half_eff;
   logic [7:0]  timeout_eff;
   logic [23:0] window_in;
   uart_trx_pkg::timing_type timing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_cfg_ff    <= uart_trx_pkg::HALF_BIT_RESET;
         timeout_cfg_ff <= uart_trx_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            uart_trx_pkg::CSR_HALF_BIT_TICKS:    half_cfg_ff    <= csr_wdata;
            uart_trx_pkg::CSR_TIMEOUT_HALF_BITS: timeout_cfg_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // a zero count acts as one
   assign half_eff    = (half_cfg_ff == '0) ? 16'd1 : half_cfg_ff;
   assign timeout_eff = (timeout_cfg_ff == '0) ? 8'd1 : timeout_cfg_ff;
   assign window_in   = {16'd0, timeout_eff} * {8'd0, half_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.half      <= uart_trx_pkg::HALF_BIT_RESET;
         timing_ff.bit_ticks <= uart_trx_pkg::BIT_TICKS_RESET;
         timing_ff.window    <= uart_trx_pkg::WINDOW_RESET;
      end else begin
         timing_ff.half      <= half_eff;
         timing_ff.bit_ticks <= {half_eff, 1'b0};
         timing_ff.window    <= window_in;
      end
   end

   assign timing = timing_ff;

endmodule

>>> rtl/uart_trx_top_unused_guard.sv
// ----------------------------------------------------------------------------
// uart_trx_top_unused_guard
// Result formatting: merges the transmit and receive outputs of one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_trx_top_unused_guard (
   input  uart_trx_pkg::tx_out_type tx_out,
   input  uart_trx_pkg::rx_out_type rx_out,
   output uart_trx_pkg::rsp_type    rsp
);

   always_comb begin
      rsp.tx_line = tx_out.line;
      rsp.tx_busy = tx_out.busy;
      rsp.rx_busy = rx_out.busy;
      rsp.rx_done = rx_out.done;
      // status and byte only mean something in the finishing tick
      rsp.rx_status = rx_out.done ? rx_out.status : uart_trx_pkg::RX_OK;
      rsp.rx_byte   = (rx_out.done && rx_out.status == uart_trx_pkg::RX_OK) ?
                      rx_out.data : 8'd0;
   end

endmodule

>>> rtl/uart_8n1_tx_rx.sv
// ----------------------------------------------------------------------------
// uart_8n1_tx_rx
// 8N1 UART transceiver, one request per clock tick of the bit timing.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per tick carries the sampled receive line, the
//            receive-arm strobe, the transmit start strobe and its byte.
//   rsp_*  : one response per request: transmit line level, busy flags,
//            and the receive completion (done, status, byte).
//   csr_*  : write port for half_bit_ticks (index 0) and timeout_half_bits
//            (index 1); write only while no request is in flight.
// Path: a request waits in the input stage, steps the sequencers on advance
//   and lands in the result stage; rsp_valid is high from then until taken.
// Throughput: one request per cycle unless stalled; a single pass through the
//   transmit and receive sequencers between the input and result registers.
// Reset: both sequencers go idle, timing returns to 456 ticks per half bit
//   and a timeout of 10 half bits; input and result stages empty.
// Stall: with rsp_ready low the result stage holds; one more request is
//   taken into the input stage, then req_ready drops until the result moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uart_8n1_tx_rx (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  uart_trx_pkg::req_type req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output uart_trx_pkg::rsp_type rsp_data,
   // configuration
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   uart_trx_pkg::req_type    in_ff;
   logic                     in_valid_ff;
   uart_trx_pkg::rsp_type    out_ff, out_in;
   logic                     out_valid_ff;
   logic                     advance;
   uart_trx_pkg::timing_type timing;
   uart_trx_pkg::tx_out_type tx_out;
   uart_trx_pkg::rx_out_type rx_out;

   // Advance one tick when the input stage holds a request and the result
   // stage is empty or being drained this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input stage: take a new request when empty or as the held one moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
   end

   // Timing registers and their derived bit and window lengths.
   uart_trx_timing u_timing (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   // Transmit and receive sequencers step once per advanced request.
   uart_trx_tx u_tx (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .tx_start (in_ff.tx_start),
      .tx_byte  (in_ff.tx_byte),
      .timing   (timing),
      .tx_out   (tx_out)
   );

   uart_trx_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_line (in_ff.rx_line),
      .rx_arm  (in_ff.rx_arm),
      .timing  (timing),
      .rx_out  (rx_out)
   );

   uart_trx_top_unused_guard u_fmt (
      .tx_out (tx_out),
      .rx_out (rx_out),
      .rsp    (out_in)
   );

   // Result stage: load on advance, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // An advanced request always lands in the result stage.
   `ASSERT_NEXT(a_advance_fills, clock, reset, advance, out_valid_ff,
                "advanced request did not reach the result stage")

   // A held request stays put while the result stage is blocked.
   `ASSERT_NEXT(a_input_holds, clock, reset, in_valid_ff && !advance,
                in_valid_ff && $stable(in_ff), "held request lost or changed")

   // A finished receive attempt is always reported with the receiver busy.
   `ASSERT_CLK(a_done_busy, clock, reset,
               !out_valid_ff || !out_ff.rx_done || out_ff.rx_busy,
               "rx_done without rx_busy")

   // The transmit line idles high outside a frame.
   `ASSERT_CLK(a_tx_idle_high, clock, reset,
               !out_valid_ff || out_ff.tx_busy || out_ff.tx_line,
               "tx_line low while transmitter idle")

endmodule

>>> sim/uart_8n1_tx_rx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8n1_tx_rx_checker
// Watches the request, response and register ports of the UART transceiver,
// predicts the line and receive outputs of every tick and compares them.
// ----------------------------------------------------------------------------

module uart_8n1_tx_rx_checker
   import uart_trx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          in_flight
);

   // Timing registers as last written
   logic [15:0] half_cfg;
   logic [7:0]  timeout_cfg;

   // Transmit sequencer
   tx_phase_type tx_ph;
   logic [7:0]   tx_sh;
   logic [3:0]   tx_bits;
   logic [16:0]  tx_ticks;

   // Receive sequencer
   rx_phase_type rx_ph;
   logic [7:0]   rx_sh;
   logic [3:0]   rx_bits;
   logic [23:0]  rx_ticks;

   rsp_type expected_tick_q[$];
   rsp_type model_out;
   int      rsp_count;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t checker: tick %0d %s got %0h want %0h",
               $realtime, rsp_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch(what, 32'(got), 32'(want));
   endtask

   // Advance both sequencers by one tick and return the outputs of that tick.
   task automatic step_line_model(input req_type r, output rsp_type y);
      logic [16:0] h;
      logic [16:0] bit_t;
      logic [23:0] t_eff;
      logic [23:0] window;
      h      = (half_cfg == '0) ? 17'd1 : {1'b0, half_cfg};
      bit_t  = h << 1;
      t_eff  = (timeout_cfg == '0) ? 24'd1 : {16'd0, timeout_cfg};
      window = t_eff * {7'd0, h};
      y         = '0;
      y.tx_line = 1'b1;

      if (tx_ph == TX_IDLE && r.tx_start) begin
         tx_sh    = r.tx_byte;
         tx_ph    = TX_START;
         tx_ticks = '0;
         tx_bits  = '0;
      end
      if (tx_ph != TX_IDLE) begin
         y.tx_busy = 1'b1;
         case (tx_ph)
            TX_START: y.tx_line = 1'b0;
            TX_DATA:  y.tx_line = tx_sh[0];
            default:  y.tx_line = 1'b1;
         endcase
         tx_ticks = tx_ticks + 17'd1;
         if (tx_ticks >= bit_t) begin
            tx_ticks = '0;
            case (tx_ph)
               TX_START: begin
                  tx_ph   = TX_DATA;
                  tx_bits = '0;
               end
               TX_DATA: begin
                  tx_sh   = tx_sh >> 1;
                  tx_bits = tx_bits + 4'd1;
                  if (tx_bits >= 4'(DATA_BITS))
                     tx_ph = TX_STOP;
               end
               default: begin
                  tx_ph   = TX_IDLE;
                  tx_bits = '0;
               end
            endcase
         end
      end

      if (rx_ph == RX_IDLE && r.rx_arm) begin
         rx_ph    = RX_WAIT;
         rx_ticks = '0;
      end
      if (rx_ph != RX_IDLE) begin
         y.rx_busy = 1'b1;
         case (rx_ph)
            RX_WAIT: begin
               if (rx_ticks >= window) begin
                  y.rx_done   = 1'b1;
                  y.rx_status = RX_TIMEOUT;
                  rx_ph       = RX_IDLE;
                  rx_ticks    = '0;
               end else if (!r.rx_line) begin
                  rx_ph    = RX_START;
                  rx_ticks = '0;
               end else begin
                  rx_ticks = rx_ticks + 24'd1;
               end
            end
            RX_START: begin
               rx_ticks = rx_ticks + 24'd1;
               if (rx_ticks >= {7'd0, h}) begin
                  rx_ticks = '0;
                  if (r.rx_line) begin
                     y.rx_done   = 1'b1;
                     y.rx_status = RX_FALSE_START;
                     rx_ph       = RX_IDLE;
                  end else begin
                     rx_ph   = RX_DATA;
                     rx_sh   = '0;
                     rx_bits = '0;
                  end
               end
            end
            RX_DATA: begin
               rx_ticks = rx_ticks + 24'd1;
               if (rx_ticks >= {7'd0, bit_t}) begin
                  rx_ticks = '0;
                  rx_sh    = {r.rx_line, rx_sh[7:1]};
                  rx_bits  = rx_bits + 4'd1;
                  if (rx_bits >= 4'(DATA_BITS))
                     rx_ph = RX_STOP;
               end
            end
            default: begin
               // stop level is not looked at
               rx_ticks = rx_ticks + 24'd1;
               if (rx_ticks >= {7'd0, bit_t}) begin
                  rx_ticks    = '0;
                  y.rx_done   = 1'b1;
                  y.rx_status = RX_OK;
                  y.rx_byte   = rx_sh;
                  rx_ph       = RX_IDLE;
                  rx_bits     = '0;
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         half_cfg    = HALF_BIT_RESET;
         timeout_cfg = TIMEOUT_RESET;
         tx_ph       = TX_IDLE;
         tx_sh       = '0;
         tx_bits     = '0;
         tx_ticks    = '0;
         rx_ph       = RX_IDLE;
         rx_sh       = '0;
         rx_bits     = '0;
         rx_ticks    = '0;
         expected_tick_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HALF_BIT_TICKS:    half_cfg    = csr_wdata;
               CSR_TIMEOUT_HALF_BITS: timeout_cfg = csr_wdata[7:0];
               default: ;
            endcase
         end
         // retire before predicting so a stray response never meets a fresh tick
         if (rsp_valid && rsp_ready) begin
            if (expected_tick_q.size() == 0) begin
               report_mismatch("response with nothing expected", 32'(rsp_data), '0);
            end else begin
               model_out = expected_tick_q.pop_front();
               check_field("tx_line", 8'(rsp_data.tx_line), 8'(model_out.tx_line));
               check_field("tx_busy", 8'(rsp_data.tx_busy), 8'(model_out.tx_busy));
               check_field("rx_busy", 8'(rsp_data.rx_busy), 8'(model_out.rx_busy));
               check_field("rx_done", 8'(rsp_data.rx_done), 8'(model_out.rx_done));
               check_field("rx_status", 8'(rsp_data.rx_status), 8'(model_out.rx_status));
               check_field("rx_byte", rsp_data.rx_byte, model_out.rx_byte);
            end
            rsp_count++;
         end
         if (req_valid && req_ready) begin
            step_line_model(req_data, model_out);
            expected_tick_q.push_back(model_out);
         end
      end
      in_flight <= expected_tick_q.size();
   end

endmodule

>>> sim/tb_uart_8n1_tx_rx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_8n1_tx_rx
// Drives tick requests into the 8N1 transceiver: serial frames, glitches,
// silent lines and noise on the receive side, random transmit starts, under
// several bit timings and idle/stall mixes. A checker beside the block
// predicts every response; this module only makes stimulus and rules.
// ----------------------------------------------------------------------------

module tb_uart_8n1_tx_rx;
   import uart_trx_pkg::*;

   // Register index that maps to nothing; writes there must not disturb timing.
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int          SETTLE_CYCLES = 3;    // margin after the last response
   localparam int          HOLD_CYCLES   = 200;  // long response hold-off
   localparam int          WAVE_CAP      = 400;  // longest level run per push

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = CSR_HALF_BIT_TICKS;
   logic [15:0] csr_wdata = '0;

   int mismatch_count;
   int in_flight;

   // Idle and stall mix of the current phase, in percent
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   // Hold-off handshake between stimulus and the response-ready process
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   int unsigned cycle_count = 0;

   // Planned receive line levels, one per tick, and an arm for the next tick
   bit wave_q[$];
   bit arm_pending = 1'b0;

   // Timing as programmed, for shaping the receive waveform
   int cur_half    = int'(HALF_BIT_RESET);
   int cur_timeout = int'(TIMEOUT_RESET);

   uart_8n1_tx_rx u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   uart_8n1_tx_rx_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .in_flight      (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response side: honor a pending hold-off first, else stall at random.
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: give up well past the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_uart_8n1_tx_rx: done, errors");
         $finish;
      end
   end

   // Bias bytes toward all zeros and all ones, else random.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Offer one tick; optionally idle first, then hold valid until taken.
   task automatic send_tick(input logic line, input logic arm, input logic start,
                            input logic [7:0] data);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= '{rx_line: line, rx_arm: arm, tx_start: start, tx_byte: data};
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every response is back, then SETTLE_CYCLES more.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Queue n ticks of one line level, clipped so huge bit times stay cheap.
   task automatic push_wave(input bit level, input int n);
      int k;
      k = (n > WAVE_CAP) ? WAVE_CAP : n;
      repeat (k) wave_q.push_back(level);
   endtask

   // Plan the next stretch of receive activity: mostly clean frames,
   // some short start glitches, silent lines long enough to time out,
   // and a little raw noise. Arm the receiver on the first tick most times.
   task automatic plan_rx_activity();
      int          h;
      int          t;
      int          pick;
      int          n;
      logic [7:0]  b;
      h    = (cur_half == 0) ? 1 : cur_half;
      t    = (cur_timeout == 0) ? 1 : cur_timeout;
      pick = $urandom_range(99);
      arm_pending = ($urandom_range(9) != 0);
      if (pick < 70) begin
         // idle gap, start, eight data bits LSB first, stop (sometimes low)
         push_wave(1'b1, $urandom_range(3 * h));
         push_wave(1'b0, 2 * h);
         b = pick_byte();
         for (int i = 0; i < 8; i++)
            push_wave(b[i], 2 * h);
         push_wave($urandom_range(7) != 0, 2 * h);
      end else if (pick < 80) begin
         // low pulse gone by mid-bit: false start
         n = $urandom_range(h, 1);
         push_wave(1'b0, n);
         push_wave(1'b1, h + 1);
      end else if (pick < 95) begin
         // quiet line past the window: start timeout
         push_wave(1'b1, t * h + $urandom_range(3));
      end else begin
         n = $urandom_range(8, 1);
         repeat (n) push_wave(1'($urandom_range(1)), 1);
      end
   endtask

   // Random ticks: receive line from the plan, random arms and transmits.
   task automatic run_traffic(input int count);
      logic line;
      logic arm;
      repeat (count) begin
         if (wave_q.size() == 0)
            plan_rx_activity();
         line        = wave_q.pop_front();
         arm         = arm_pending || ($urandom_range(23) == 0);
         arm_pending = 1'b0;
         send_tick(line, arm, $urandom_range(11) == 0, pick_byte());
      end
   endtask

   // Drain, write both timing registers and the spare index, then set the
   // idle and stall mix for the next phase. The sequencers may still be mid-frame.
   task automatic begin_phase(input logic [15:0] half_data,
                              input logic [15:0] timeout_data,
                              input int sender_pct, input int stall_pct);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_HALF_BIT_TICKS;
      csr_wdata <= half_data;
      @(posedge clock);
      csr_index <= CSR_TIMEOUT_HALF_BITS;
      csr_wdata <= timeout_data;
      @(posedge clock);
      csr_index <= CSR_SPARE_INDEX;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
      cur_half        = int'(half_data);
      cur_timeout     = int'(timeout_data[7:0]);
      sender_idle_pct = sender_pct;
      rsp_stall_pct   = stall_pct;
      wave_q.delete();
      arm_pending = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset timing: start a frame of zeros and arm with the line idle.
      send_tick(1'b1, 1'b1, 1'b1, 8'h00);
      // Line drops to reach the start check; transmit start while busy is dropped.
      send_tick(1'b0, 1'b0, 1'b1, 8'hFF);
      // Arm while receiving is dropped too.
      send_tick(1'b1, 1'b1, 1'b0, 8'h5A);

      // Shortest timing; the line is high at the start check: false start.
      // Keep the line idle until the transmit frame is out.
      begin_phase(16'd1, 16'd1, 0, 0);
      repeat (20) send_tick(1'b1, 1'b0, 1'b0, 8'h00);
      // Arm on a quiet line: timeout after one half bit.
      send_tick(1'b1, 1'b1, 1'b0, 8'h00);
      send_tick(1'b1, 1'b0, 1'b0, 8'h00);

      // Random phases across timings and idle mixes.
      begin_phase(16'd1, 16'd1, 0, 0);
      run_traffic(140);

      begin_phase(16'd2, 16'd3, 63, 0);
      run_traffic(150);

      // Longest timeout; hold responses off so the block fills and stalls.
      begin_phase(16'd3, {8'($urandom), 8'd255}, 0, 63);
      hold_requests = hold_requests + 1;
      run_traffic(150);

      // Zero registers behave as one.
      begin_phase(16'd0, 16'd0, 37, 37);
      run_traffic(120);

      // Largest values: only a handful of ticks, nothing completes.
      begin_phase(16'hFFFF, 16'hFFFF, 0, 0);
      run_traffic(20);

      begin_phase(16'd1, {8'($urandom), 8'd2}, 37, 37);
      run_traffic(140);

      begin_phase(16'd4, 16'd2, 63, 0);
      run_traffic(150);

      begin_phase(16'd2, 16'd1, 0, 0);
      hold_requests = hold_requests + 1;
      run_traffic(150);

      settle();
      if (mismatch_count == 0) begin
         $display("tb_uart_8n1_tx_rx: done, clean");
      end else begin
         $display("tb_uart_8n1_tx_rx: done, errors");
      end
      $finish;
   end

endmodule
